// ----- rtl/ccc_pkg.sv -----
// Shared types, codes and constants of the coincidence cone builder.
// Used by ccc_cell, ccc_angle, the top module and the bench; depends on nothing.
package ccc_pkg;

  localparam int EVENT_DEPTH_DEF    = 64;
  localparam int DETECTOR_COUNT_DEF = 16;

  typedef enum logic [1:0] {
    OP_DET_WRITE = 2'd0,
    OP_APPEND    = 2'd1,
    OP_QUERY     = 2'd2,
    OP_CLEAR     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_SOURCE_ENERGY = 2'd0,
    CFG_IMAGE_HEIGHT  = 2'd1,
    CFG_WINDOW_TOL    = 2'd2
  } cfg_reg_t;

  localparam logic [19:0]        SOURCE_ENERGY_RST = 20'd10592;
  localparam logic signed [23:0] IMAGE_HEIGHT_RST  = 24'sd0;
  localparam logic [15:0]        WINDOW_TOL_RST    = 16'd10;

  // 511 keV in Q.4
  localparam logic [13:0]        ENERGY_511  = 14'd8176;
  localparam logic signed [17:0] HALF_PI_Q14 = 18'sd25736;
  localparam logic signed [17:0] PI_Q14      = 18'sd51472;

  typedef struct packed {
    logic signed [31:0] ev_time;
    logic [19:0]        energy;
    logic [3:0]         det;
  } ccc_entry_t;

  function automatic logic [13:0] atan_q14(input logic [3:0] i);
    logic [13:0] v;
    unique case (i)
      4'd0:    v = 14'd12868;
      4'd1:    v = 14'd7596;
      4'd2:    v = 14'd4014;
      4'd3:    v = 14'd2037;
      4'd4:    v = 14'd1023;
      4'd5:    v = 14'd512;
      4'd6:    v = 14'd256;
      4'd7:    v = 14'd128;
      4'd8:    v = 14'd64;
      4'd9:    v = 14'd32;
      4'd10:   v = 14'd16;
      4'd11:   v = 14'd8;
      4'd12:   v = 14'd4;
      4'd13:   v = 14'd2;
      4'd14:   v = 14'd1;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/ccc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ccc_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);
  logic [W-1:0] mem_r [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ----- rtl/ccc_cell.sv -----
// One absorption list cell: loads a new word or takes its neighbor's word.
// Depends on ccc_pkg.
module ccc_cell (
  input  logic               clk,
  input  logic               shift_en,
  input  logic               load_en,
  input  ccc_pkg::ccc_entry_t load_data,
  input  ccc_pkg::ccc_entry_t next_data,
  output ccc_pkg::ccc_entry_t data_q
);
  import ccc_pkg::*;

  ccc_entry_t data_r, data_nxt;

  always_comb begin
    priority if (load_en) begin
      data_nxt = load_data;
    end else if (shift_en) begin
      data_nxt = next_data;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;
endmodule

// ----- rtl/ccc_div.sv -----
// Restoring divider, one quotient bit per cycle; the quotient is STEPS bits wide.
// Remainder starts at rem_init (below divisor); dividend bits shift in.
module ccc_div #(
  parameter int DVW   = 25,
  parameter int STEPS = 50
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVW-1:0]   rem_init,
  input  logic [STEPS-1:0] dividend,
  input  logic [DVW-1:0]   divisor,
  output logic [STEPS-1:0] quot,
  output logic             done
);
  localparam int CW = $clog2(STEPS + 1);

  logic [DVW-1:0]   rem_r, div_r;
  logic [STEPS-1:0] low_r, quot_r;
  logic [CW-1:0]    cnt_r;
  logic             run_r, done_r;
  logic [DVW:0]     trial, diff;
  logic             ge;

  always_comb begin
    trial = {rem_r, low_r[STEPS-1]};
    ge    = trial >= {1'b0, div_r};
    diff  = trial - {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CW'(STEPS - 1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= rem_init;
      low_r  <= dividend;
      div_r  <= divisor;
      quot_r <= '0;
    end else if (run_r) begin
      rem_r  <= ge ? diff[DVW-1:0] : trial[DVW-1:0];
      low_r  <= {low_r[STEPS-2:0], 1'b0};
      quot_r <= {quot_r[STEPS-2:0], ge};
    end
  end

  assign quot = quot_r;
  assign done = done_r;
endmodule

// ----- rtl/ccc_angle.sv -----
// Arccosine unit: squares the cosine, takes the sine by a bit-pair square
// root (31 steps), then runs 15 CORDIC vectoring steps. Depends on ccc_pkg.
module ccc_angle (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] cos_in,
  output logic [15:0]        angle,
  output logic               done
);
  import ccc_pkg::*;

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_SQR  = 4'b0010,
    A_ROOT = 4'b0100,
    A_ROT  = 4'b1000
  } ang_state_t;

  ang_state_t         state_r, state_nxt;
  logic               neg_r, done_r;
  logic [30:0]        cc_r;
  logic [60:0]        v_r, bit_r, root_r, root_nxt;
  logic signed [33:0] x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic signed [17:0] z_r, z_nxt, at;
  logic [3:0]         i_r;
  logic [15:0]        angle_r;
  logic [61:0]        sq, sum;
  logic               ge;
  logic [31:0]        cmag;

  always_comb begin
    cmag     = cos_in[31] ? 32'(-cos_in) : 32'(cos_in);
    sq       = cc_r * cc_r;
    sum      = {1'b0, root_r} + {1'b0, bit_r};
    ge       = {1'b0, v_r} >= sum;
    root_nxt = ge ? (root_r >> 1) + bit_r : root_r >> 1;
    xs       = x_r >>> i_r;
    ys       = y_r >>> i_r;
    at       = $signed({4'b0, atan_q14(i_r)});
    if (!y_r[33]) begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + at;
    end else begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - at;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      A_IDLE:  if (start) state_nxt = A_SQR;
      A_SQR:   state_nxt = A_ROOT;
      A_ROOT:  if (bit_r[0]) state_nxt = A_ROT;
      A_ROT:   if (i_r == 4'd14) state_nxt = A_IDLE;
      default: state_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == A_IDLE && start) begin
        done_r <= 1'b0;
      end else if (state_r == A_ROT && i_r == 4'd14) begin
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      A_IDLE: begin
        neg_r <= cos_in[31];
        cc_r  <= cmag[30:0];
      end
      A_SQR: begin
        v_r    <= 61'((62'(1) << 60) - sq);
        bit_r  <= 61'(1) << 60;
        root_r <= '0;
      end
      A_ROOT: begin
        if (ge) begin
          v_r <= v_r - sum[60:0];
        end
        root_r <= root_nxt;
        bit_r  <= bit_r >> 2;
        // set up the rotation once the sine is complete
        i_r <= 4'd0;
        if (neg_r) begin
          x_r <= $signed({3'b0, root_nxt[30:0]});
          y_r <= $signed({3'b0, cc_r});
          z_r <= HALF_PI_Q14;
        end else begin
          x_r <= $signed({3'b0, cc_r});
          y_r <= $signed({3'b0, root_nxt[30:0]});
          z_r <= '0;
        end
      end
      A_ROT: begin
        x_r <= x_nxt;
        y_r <= y_nxt;
        z_r <= z_nxt;
        i_r <= i_r + 4'd1;
        priority if (z_nxt < 0) begin
          angle_r <= '0;
        end else if (z_nxt > PI_Q14) begin
          angle_r <= PI_Q14[15:0];
        end else begin
          angle_r <= z_nxt[15:0];
        end
      end
      default: ;
    endcase
  end

  assign angle = angle_r;
  assign done  = done_r;
endmodule

// ----- rtl/compton_coincidence_cone_top.sv -----
// Channel  | ports                                   | handshake
// input    | start, busy, in_*                       | accepted when start && !busy
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data | written when valid && ready
// result   | out_valid, out_*                        | one-cycle strobe, no stall
//
// Detector write, append and clear are taken without leaving idle. A query rotates the
// absorption cell ring once, then goes back to idle if no match.
// A match then runs two detector RAM reads, products, the 50-step crossing
// divider (the 30-step cosine divider runs alongside), then the square root
// and CORDIC in the angle unit, which is skipped when the angle is invalid.
// Reset is synchronous, active low; the receiver cannot stall results.
// Depends on ccc_pkg, ccc_ram, ccc_cell, ccc_div, ccc_angle.
module compton_coincidence_cone_top #(
  parameter int EVENT_DEPTH    = ccc_pkg::EVENT_DEPTH_DEF,
  parameter int DETECTOR_COUNT = ccc_pkg::DETECTOR_COUNT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic [3:0]         in_detector_index,
  input  logic signed [31:0] in_event_time,
  input  logic [19:0]        in_event_energy,
  input  logic signed [23:0] in_coord_x,
  input  logic signed [23:0] in_coord_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  output logic               out_valid,
  output logic signed [23:0] out_apex_x,
  output logic signed [23:0] out_apex_z,
  output logic signed [23:0] out_plane_x,
  output logic [15:0]        out_cone_angle,
  output logic [5:0]         out_matched_entry,
  output logic               out_angle_invalid,
  output logic               out_plane_invalid,
  output logic               out_list_overflowed
);
  import ccc_pkg::*;

  localparam int CNTW = $clog2(EVENT_DEPTH + 1);
  localparam int DAW  = $clog2(DETECTOR_COUNT);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SCAN = 9'b000000010,
    S_RDS  = 9'b000000100,
    S_RDA  = 9'b000001000,
    S_RDB  = 9'b000010000,
    S_MUL  = 9'b000100000,
    S_CHK  = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  function automatic logic det_ok(input logic [3:0] d);
    return 32'(d) < 32'(DETECTOR_COUNT);
  endfunction

  function automatic logic [DAW-1:0] det_addr(input logic [3:0] d);
    logic [DAW+3:0] w;
    w = (DAW + 4)'(d);
    return w[DAW-1:0];
  endfunction

  state_t state_r, state_nxt;
  logic   ang_busy_r;

  // configuration
  logic [19:0]        src_energy_r;
  logic signed [23:0] img_height_r;
  logic [15:0]        win_tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_energy_r <= SOURCE_ENERGY_RST;
      img_height_r <= IMAGE_HEIGHT_RST;
      win_tol_r    <= WINDOW_TOL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SOURCE_ENERGY: src_energy_r <= cfg_data[19:0];
        CFG_IMAGE_HEIGHT:  img_height_r <= $signed(cfg_data);
        CFG_WINDOW_TOL:    win_tol_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  logic accept;
  op_t  op;
  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign op     = op_t'(in_operation);

  // detector position RAM: {x, z}
  logic           det_we;
  logic [DAW-1:0] det_raddr;
  logic [47:0]    det_rdata;
  logic [3:0]     q_idx_r, ad_r;

  assign det_we    = accept && op == OP_DET_WRITE && det_ok(in_detector_index);
  assign det_raddr = (state_r == S_RDA) ? det_addr(ad_r) : det_addr(q_idx_r);

  ccc_ram #(.W(48), .DEPTH(DETECTOR_COUNT)) u_det_ram (
    .clk   (clk),
    .we    (det_we),
    .waddr (det_addr(in_detector_index)),
    .wdata ({in_coord_x, in_coord_z}),
    .raddr (det_raddr),
    .rdata (det_rdata)
  );

  // absorption list: ring of cells, cell 0 is the head examined by the scan
  logic [CNTW-1:0] cnt_r, k_r, j_r;
  logic            ovf_r;
  ccc_entry_t      cell_q [EVENT_DEPTH];
  ccc_entry_t      new_entry;
  logic            append;

  assign new_entry = '{ev_time: in_event_time, energy: in_event_energy,
                       det: in_detector_index};
  assign append    = accept && op == OP_APPEND;

  for (genvar i = 0; i < EVENT_DEPTH; i++) begin : g_cell
    ccc_cell u_cell (
      .clk       (clk),
      .shift_en  (state_r == S_SCAN),
      .load_en   (append && cnt_r == CNTW'(i)),
      .load_data (new_entry),
      .next_data (cell_q[(i + 1) % EVENT_DEPTH]),
      .data_q    (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (accept) begin
      if (op == OP_APPEND) begin
        if (cnt_r < CNTW'(EVENT_DEPTH)) begin
          cnt_r <= cnt_r + 1'b1;
        end else begin
          ovf_r <= 1'b1;
        end
      end else if (op == OP_CLEAR) begin
        cnt_r <= '0;
      end
    end
  end

  // coincidence test on the head cell
  logic signed [31:0] q_time_r;
  logic signed [32:0] tdiff, tol;
  logic               hit, found_r;

  always_comb begin
    tdiff = 33'(q_time_r) - 33'(cell_q[0].ev_time);
    tol   = $signed({17'b0, win_tol_r});
    hit   = !found_r && (k_r < cnt_r) && (tdiff < tol) && (tdiff > -tol);
  end

  // cone arithmetic
  logic signed [23:0] xs_r, zs_r, xa_r, za_r;
  logic [19:0]        ef_r;
  logic signed [49:0] prod_r;
  logic signed [24:0] dz_r;
  logic [39:0]        den_r;
  logic signed [35:0] num_r;
  logic               ezero_r, ainv_r, pinv_r, a_neg_r, unit_r, p_neg_r;
  logic signed [24:0] dx, dz, hz;
  logic signed [20:0] ediff;
  logic signed [42:0] a_val;
  logic [42:0]        a_mag;
  logic               ainv_c;
  logic [49:0]        pmag;
  logic [24:0]        dzmag;

  always_comb begin
    dx     = 25'(xa_r) - 25'(xs_r);
    dz     = 25'(za_r) - 25'(zs_r);
    hz     = 25'(img_height_r) + 25'(zs_r);
    ediff  = $signed({1'b0, src_energy_r}) - $signed({1'b0, ef_r});
    ainv_c = ezero_r || num_r[35] ||
             (43'(num_r) > $signed({2'b0, den_r, 1'b0}));
    a_val  = $signed({3'b0, den_r}) - 43'(num_r);
    a_mag  = a_val[42] ? 43'(-a_val) : 43'(a_val);
    pmag   = prod_r[49] ? 50'(-prod_r) : 50'(prod_r);
    dzmag  = dz_r[24] ? 25'(-dz_r) : 25'(dz_r);
  end

  logic        rdiv_start, pdiv_start, rdone, pdone, ang_start, ang_done;
  logic [29:0] rquot;
  logic [49:0] pquot;
  logic [15:0] ang_val;
  logic [31:0] cmag;
  logic signed [31:0] cos_val;
  logic        div_ready;

  assign rdiv_start = (state_r == S_CHK) && !ainv_c && (a_mag[39:0] != den_r);
  assign pdiv_start = (state_r == S_CHK) && (dz_r != '0);
  assign div_ready  = (pinv_r || pdone) && (ainv_r || unit_r || rdone);
  assign ang_start  = (state_r == S_DIV) && div_ready && !ainv_r;
  assign cmag       = unit_r ? 32'h4000_0000 : {2'b0, rquot};
  assign cos_val    = a_neg_r ? -$signed(cmag) : $signed(cmag);

  ccc_div #(.DVW(40), .STEPS(30)) u_ratio_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rdiv_start),
    .rem_init (a_mag[39:0]),
    .dividend ('0),
    .divisor  (den_r),
    .quot     (rquot),
    .done     (rdone)
  );

  ccc_div #(.DVW(25), .STEPS(50)) u_plane_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (pdiv_start),
    .rem_init ('0),
    .dividend (pmag),
    .divisor  (dzmag),
    .quot     (pquot),
    .done     (pdone)
  );

  ccc_angle u_angle (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ang_start),
    .cos_in (cos_val),
    .angle  (ang_val),
    .done   (ang_done)
  );

  // crossing: x_s minus the signed quotient, saturated
  logic signed [51:0] qs, px;
  logic [23:0]        px_sat;

  always_comb begin
    qs = p_neg_r ? -$signed({2'b0, pquot}) : $signed({2'b0, pquot});
    px = 52'(xs_r) - qs;
    priority if (px > 52'sd8388607) begin
      px_sat = 24'h7F_FFFF;
    end else if (px < -52'sd8388608) begin
      px_sat = 24'h80_0000;
    end else begin
      px_sat = px[23:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept && op == OP_QUERY) state_nxt = S_SCAN;
      S_SCAN: begin
        if (k_r == CNTW'(EVENT_DEPTH - 1)) begin
          state_nxt = (found_r || hit) ? S_RDS : S_IDLE;
        end
      end
      S_RDS:  state_nxt = S_RDA;
      S_RDA:  state_nxt = S_RDB;
      S_RDB:  state_nxt = S_MUL;
      S_MUL:  state_nxt = S_CHK;
      S_CHK:  state_nxt = S_DIV;
      S_DIV: begin
        if (ang_busy_r) begin
          if (ang_done) state_nxt = S_OUT;
        end else if (div_ready && ainv_r) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ang_busy_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ang_start) begin
        ang_busy_r <= 1'b1;
      end else if (state_r == S_OUT) begin
        ang_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        q_time_r <= in_event_time;
        q_idx_r  <= in_detector_index;
        k_r      <= '0;
        found_r  <= 1'b0;
      end
      S_SCAN: begin
        k_r <= k_r + 1'b1;
        if (hit) begin
          found_r <= 1'b1;
          j_r     <= k_r;
          ef_r    <= cell_q[0].energy;
          ad_r    <= cell_q[0].det;
        end
      end
      S_RDA: begin
        xs_r <= det_ok(q_idx_r) ? $signed(det_rdata[47:24]) : '0;
        zs_r <= det_ok(q_idx_r) ? $signed(det_rdata[23:0]) : '0;
      end
      S_RDB: begin
        xa_r <= det_ok(ad_r) ? $signed(det_rdata[47:24]) : '0;
        za_r <= det_ok(ad_r) ? $signed(det_rdata[23:0]) : '0;
      end
      S_MUL: begin
        prod_r  <= hz * dx;
        dz_r    <= dz;
        den_r   <= ef_r * src_energy_r;
        num_r   <= $signed({1'b0, ENERGY_511}) * ediff;
        ezero_r <= (ef_r == '0) || (src_energy_r == '0);
      end
      S_CHK: begin
        ainv_r  <= ainv_c;
        pinv_r  <= (dz_r == '0);
        a_neg_r <= a_val[42];
        unit_r  <= (a_mag[39:0] == den_r);
        p_neg_r <= prod_r[49] ^ dz_r[24];
      end
      default: ;
    endcase
  end

  // result registers
  logic               out_valid_r;
  logic signed [23:0] apex_x_r, apex_z_r, plane_x_r;
  logic [15:0]        angle_r;
  logic [5:0]         entry_r;
  logic               ainv_o_r, pinv_o_r, ovf_o_r;
  logic [CNTW+5:0]    j_ext;

  assign j_ext = (CNTW + 6)'(j_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_OUT);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT) begin
      apex_x_r  <= xs_r;
      apex_z_r  <= zs_r;
      plane_x_r <= pinv_r ? '0 : $signed(px_sat);
      angle_r   <= ainv_r ? '0 : ang_val;
      entry_r   <= j_ext[5:0];
      ainv_o_r  <= ainv_r;
      pinv_o_r  <= pinv_r;
      ovf_o_r   <= ovf_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_apex_x          = apex_x_r;
  assign out_apex_z          = apex_z_r;
  assign out_plane_x         = plane_x_r;
  assign out_cone_angle      = angle_r;
  assign out_matched_entry   = entry_r;
  assign out_angle_invalid   = ainv_o_r;
  assign out_plane_invalid   = pinv_o_r;
  assign out_list_overflowed = ovf_o_r;

  a_out_after_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_OUT))
    else $error("result strobe without a finished query");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(EVENT_DEPTH))
    else $error("absorption count beyond list depth");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op == OP_QUERY) |=> busy)
    else $error("query accepted but block not busy");

  a_match_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RDS) |-> (j_r < cnt_r))
    else $error("matched entry beyond stored count");
endmodule

// ----- tb/compton_coincidence_cone_top_tb.sv -----
// Self-checking bench for compton_coincidence_cone_top: a directed table, then random phases.
// Holds its own cone predictor; depends on ccc_pkg and the RTL under rtl.
module compton_coincidence_cone_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ccc_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 250;
  localparam int DEPTH = 64;

  typedef struct packed {
    logic signed [23:0] apex_x;
    logic signed [23:0] apex_z;
    logic signed [23:0] plane_x;
    logic [15:0]        angle;
    logic [5:0]         entry;
    logic               ainv;
    logic               pinv;
    logic               ovf;
  } cone_t;

  typedef struct {
    op_t                op;
    logic [3:0]         idx;
    logic signed [31:0] t;
    logic [19:0]        e;
    logic signed [23:0] x;
    logic signed [23:0] z;
    bit                 typed;
    bit                 want_hit;
    cone_t              want;
  } word_t;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [1:0] in_operation = '0;
  logic [3:0] in_detector_index = '0;
  logic signed [31:0] in_event_time = '0;
  logic [19:0] in_event_energy = '0;
  logic signed [23:0] in_coord_x = '0;
  logic signed [23:0] in_coord_z = '0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic out_valid;
  logic signed [23:0] out_apex_x, out_apex_z, out_plane_x;
  logic [15:0] out_cone_angle;
  logic [5:0] out_matched_entry;
  logic out_angle_invalid, out_plane_invalid, out_list_overflowed;

  compton_coincidence_cone_top dut (.*);

  // predictor state
  logic signed [23:0] det_x[16];
  logic signed [23:0] det_z[16];
  logic signed [31:0] ab_time[DEPTH];
  logic [19:0]        ab_energy[DEPTH];
  logic [3:0]         ab_det[DEPTH];
  int                 ab_count;
  bit                 ovf_sticky;
  logic [19:0]        src_energy;
  logic signed [23:0] img_height;
  logic [15:0]        win_tol;

  cone_t pending_cones[$];
  int    written_dets[$];
  int    mismatches = 0;
  int    cones_seen = 0;
  int    words_sent = 0;
  longint cycles = 0;

  const longint ATAN_TAB[15] = '{12868, 7596, 4014, 2037, 1023, 512, 256, 128, 64, 32,
                                 16, 8, 4, 2, 1};

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic longint root64(longint unsigned v);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // a/d in Q.30 with the magnitude floored, a in [-d, d]
  function automatic longint cos_q30(longint a, longint d);
    longint unsigned ua = (a < 0) ? -a : a;
    longint unsigned q = ua / d, r = ua % d;
    for (int k = 0; k < 30; k++) begin
      r <<= 1;
      q <<= 1;
      if (r >= d) begin
        r -= d;
        q |= 1;
      end
    end
    return (a < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint angle_q14(longint c);
    longint unsigned cc = (c < 0) ? -c : c;
    longint y = root64((64'd1 << 60) - cc * cc);
    longint x = c, z = 0, t, xs, ys;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = 25736;
    end
    for (int i = 0; i < 15; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += ATAN_TAB[i];
      end else begin
        x -= ys; y += xs; z -= ATAN_TAB[i];
      end
    end
    if (z < 0) z = 0;
    if (z > 51472) z = 51472;
    return z;
  endfunction

  task automatic predict_cone(input word_t w, output bit hit, output cone_t r);
    int j;
    longint d, xs, zs, xa, za, dx, dz, num, den, q, px, ef, e0;
    hit = 0;
    r = '0;
    case (w.op)
      OP_DET_WRITE: begin
        det_x[w.idx] = w.x;
        det_z[w.idx] = w.z;
      end
      OP_APPEND: begin
        if (ab_count < DEPTH) begin
          ab_time[ab_count] = w.t;
          ab_energy[ab_count] = w.e;
          ab_det[ab_count] = w.idx;
          ab_count++;
        end else begin
          ovf_sticky = 1;
        end
      end
      OP_CLEAR: ab_count = 0;
      default: begin
        for (j = 0; j < ab_count; j++) begin
          d = longint'(w.t) - longint'(ab_time[j]);
          if (d < longint'(win_tol) && d > -longint'(win_tol)) break;
        end
        if (j < ab_count) begin
          hit = 1;
          xs = det_x[w.idx];
          zs = det_z[w.idx];
          xa = det_x[ab_det[j]];
          za = det_z[ab_det[j]];
          ef = ab_energy[j];
          e0 = src_energy;
          if (ef == 0 || e0 == 0) begin
            r.ainv = 1;
          end else begin
            num = 8176 * (e0 - ef);
            den = ef * e0;
            if (num < 0 || num > 2 * den) r.ainv = 1;
            else r.angle = 16'(angle_q14(cos_q30(den - num, den)));
          end
          dx = xa - xs;
          dz = za - zs;
          if (dz == 0) begin
            r.pinv = 1;
          end else begin
            q = ((longint'(img_height) + zs) * dx) / dz;
            px = xs - q;
            if (px > 8388607) px = 8388607;
            if (px < -8388608) px = -8388608;
            r.plane_x = px[23:0];
          end
          r.apex_x = xs[23:0];
          r.apex_z = zs[23:0];
          r.entry = j[5:0];
          r.ovf = ovf_sticky;
        end
      end
    endcase
  endtask

  task automatic issue(input word_t w);
    bit hit;
    cone_t r;
    start <= 1;
    in_operation <= w.op;
    in_detector_index <= w.idx;
    in_event_time <= w.t;
    in_event_energy <= w.e;
    in_coord_x <= w.x;
    in_coord_z <= w.z;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
    predict_cone(w, hit, r);
    if (w.typed) begin
      hit = w.want_hit;
      r = w.want;
    end
    if (hit) pending_cones = {pending_cones, r};
    if (w.op == OP_DET_WRITE && !(w.idx inside {written_dets}))
      written_dets = {written_dets, int'(w.idx)};
  endtask

  // the caller drops cfg_valid after the last write of a group
  task automatic write_reg(input cfg_reg_t idx, input logic [23:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SOURCE_ENERGY: src_energy = val[19:0];
      CFG_IMAGE_HEIGHT:  img_height = val;
      default:           win_tol = val[15:0];
    endcase
  endtask

  // hold until every cone is out, then let a no-match scan finish
  task automatic drain();
    start <= 0;
    while (pending_cones.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cone_t got, want;
    if (rst_n && out_valid) begin
      got = '{out_apex_x, out_apex_z, out_plane_x, out_cone_angle, out_matched_entry,
              out_angle_invalid, out_plane_invalid, out_list_overflowed};
      cones_seen++;
      if (pending_cones.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected cone word %h", got);
      end else begin
        want = pending_cones.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("cone mismatch: exp ax=%0d az=%0d px=%0d ang=%0d ent=%0d fl=%b%b%b",
                     want.apex_x, want.apex_z, want.plane_x, want.angle, want.entry,
                     want.ainv, want.pinv, want.ovf,
                     "\n              got ax=%0d az=%0d px=%0d ang=%0d ent=%0d fl=%b%b%b",
                     got.apex_x, got.apex_z, got.plane_x, got.angle, got.entry,
                     got.ainv, got.pinv, got.ovf);
        end
      end
    end
  end

  function automatic word_t mk(op_t op, logic [3:0] idx, logic signed [31:0] t,
                               logic [19:0] e, logic signed [23:0] x, logic signed [23:0] z);
    word_t w;
    w = '{op, idx, t, e, x, z, 0, 0, '0};
    return w;
  endfunction

  function automatic logic signed [23:0] rand_coord();
    if ($urandom_range(0, 3) == 0) return 24'($urandom());
    return $signed(24'($urandom_range(0, 8191))) - 24'sd4096;
  endfunction

  function automatic logic [19:0] rand_energy();
    longint unsigned se;
    int unsigned lo;
    int unsigned pick = $urandom_range(0, 9);
    se = 64'(src_energy);
    lo = 32'((8176 * se + 2 * se + 8175) / (2 * se + 8176));
    if (pick == 0) return '0;
    if (pick <= 2) return 20'($urandom());
    if (lo > 32'(src_energy)) lo = 32'(src_energy);
    return 20'($urandom_range(lo, 32'(src_energy)));
  endfunction

  task automatic random_run(input int count, input int idle_pct);
    word_t w;
    int r;
    int unsigned spread;
    logic signed [31:0] base = $urandom();
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      spread = win_tol + 3;
      if ($urandom_range(0, 19) == 0) base = $urandom();
      w = mk(OP_QUERY, 4'(written_dets[$urandom_range(0, written_dets.size() - 1)]),
             base + $signed(32'($urandom_range(0, 2 * spread))) - $signed(32'(spread)),
             rand_energy(), rand_coord(), rand_coord());
      if (r < 8) begin
        w.op = OP_DET_WRITE;
        w.idx = 4'($urandom());
      end else if (r < 48) begin
        w.op = OP_APPEND;
      end else if (r < 90) begin
        w.op = OP_QUERY;
      end else if (r < 94) begin
        w.op = OP_CLEAR;
      end else begin
        w.t = $urandom();
      end
      issue(w);
      if ($urandom_range(0, 99) < idle_pct) begin
        start <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  initial begin
    word_t dir[$];
    word_t w;
    src_energy = SOURCE_ENERGY_RST;
    img_height = IMAGE_HEIGHT_RST;
    win_tol = WINDOW_TOL_RST;
    ab_count = 0;
    ovf_sticky = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    dir = {dir, mk(OP_DET_WRITE, 0, 0, 0, 0, 0)};
    dir = {dir, mk(OP_DET_WRITE, 1, 0, 0, 100, 160)};
    dir = {dir, mk(OP_DET_WRITE, 2, 0, 0, 24'sd8388607, 24'sd8388607)};
    dir = {dir, mk(OP_DET_WRITE, 3, 0, 0, -24'sd8388608, -24'sd8388608)};
    w = mk(OP_QUERY, 0, 5, 0, 0, 0);
    w.typed = 1;
    dir = {dir, w};  // empty list gives nothing
    dir = {dir, mk(OP_APPEND, 1, 1000, 20'd10592, 0, 0)};
    w = mk(OP_QUERY, 0, 1010, 0, 0, 0);
    w.typed = 1;
    dir = {dir, w};  // distance equal to tolerance is outside
    dir = {dir, mk(OP_QUERY, 0, 1009, 0, 0, 0)};
    dir = {dir, mk(OP_APPEND, 0, 32'sh80000000, 0, 0, 0)};
    w = mk(OP_QUERY, 0, 32'sh80000001, 0, 0, 0);
    w.typed = 1;
    w.want_hit = 1;
    w.want = '{0, 0, 0, 0, 6'd1, 1'b1, 1'b1, 1'b0};
    dir = {dir, w};  // zero energy and zero dz
    dir = {dir, mk(OP_APPEND, 2, 32'sh7fffffff, 20'hfffff, 0, 0)};
    dir = {dir, mk(OP_QUERY, 3, 32'sh7ffffffe, 20'hfffff, 24'hffffff, 24'hffffff)};
    dir = {dir, mk(OP_QUERY, 2, 32'sh7fffffff, 0, 0, 0)};
    dir = {dir, mk(OP_CLEAR, 0, 0, 0, 0, 0)};
    w = mk(OP_QUERY, 2, 32'sh7fffffff, 0, 0, 0);
    w.typed = 1;
    dir = {dir, w};  // cleared list gives nothing
    foreach (dir[i]) issue(dir[i]);
    random_run(300, 0);
    drain();

    write_reg(CFG_SOURCE_ENERGY, 24'hfffff);
    write_reg(CFG_IMAGE_HEIGHT, 24'h7fffff);
    write_reg(CFG_WINDOW_TOL, 24'hffff);
    cfg_valid <= 0;
    random_run(350, 48);
    drain();

    write_reg(CFG_SOURCE_ENERGY, 24'd1);
    write_reg(CFG_IMAGE_HEIGHT, 24'h800000);
    write_reg(CFG_WINDOW_TOL, 24'd0);
    cfg_valid <= 0;
    random_run(40, 15);
    drain();

    write_reg(CFG_SOURCE_ENERGY, 24'd5000);
    write_reg(CFG_IMAGE_HEIGHT, -24'sd320);
    write_reg(CFG_WINDOW_TOL, 24'd300);
    cfg_valid <= 0;
    random_run(350, 15);
    drain();

    $display("sent %0d words over four register settings, checked %0d cones", words_sent,
             cones_seen);
    if (mismatches == 0 && pending_cones.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d cones missing", mismatches, pending_cones.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
